// File: hw/rtl/wds_pkg.sv
// Package for the weighted discrete sampler: sizes, state encoding, register
// addresses and the request and response structs of the modulo unit.
// No dependencies; the top level and wds_mod import it.
`default_nettype none

package wds_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int SUM_W       = 22;
    localparam int WEIGHT_W    = 16;
    localparam int MULT_W      = 16;
    localparam int EIU_W       = 7;
    localparam int RAND_W      = 32;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(RAND_W + 1);

    // Operation codes of an input word.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Status codes of a result word.
    localparam logic STAT_OK         = 1'b0;
    localparam logic STAT_ZERO_TOTAL = 1'b1;

    // Register select bit of the configuration address (byte address 4*i).
    localparam logic REG_MULT = 1'b0;
    localparam logic REG_EIU  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_WGT,
        ST_LD_SUM,
        ST_SM_TOT_RD,
        ST_SM_TOT_CHK,
        ST_SM_MOD,
        ST_SM_WALK
    } state_t;

    typedef struct packed {
        logic              start;
        logic [RAND_W-1:0] dividend;
        logic [SUM_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] remainder;
    } mod_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/wds_in_if.sv
// Input channel of the weighted discrete sampler: valid/ready plus the
// fields of one load or sample word. No dependencies.
`default_nettype none

interface wds_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [5:0]         entry_index;
    logic [15:0]        base_weight;
    logic signed [15:0] extra_weight;
    logic [31:0]        random_value;

    modport source (output valid, op, entry_index, base_weight, extra_weight,
                    random_value, input ready);
    modport sink (input valid, op, entry_index, base_weight, extra_weight,
                  random_value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/wds_out_if.sv
// Result channel of the weighted discrete sampler: valid/ready plus the
// chosen index and status of one result word. No dependencies.
`default_nettype none

interface wds_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] chosen_index;
    logic       status;

    modport source (output valid, chosen_index, status, input ready);
    modport sink (input valid, chosen_index, status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/weighted_discrete_sampler.sv
// Weighted discrete sampler, top level: APB register port, sequencer,
// weight arithmetic, cumulative table RAM and the modulo unit.
// Depends on wds_pkg, wds_in_if, wds_out_if, wds_ram and wds_mod.
//
// Usage: words arrive on in_ch and each gives exactly one word on out_ch.
// A load word (op 0) scales its extra weight by the Q8.8 multiplier, adds
// the base weight, clamps to 0..65535 and stores the running cumulative sum
// at its entry index; entries are loaded from index zero upwards. Its
// result is index 0, status ok. A sample word (op 1) reduces random_value
// modulo the total weight and walks the table for the first entry whose
// cumulative sum reaches remainder + 1; a zero total answers status 1.
// The block holds one word at a time: in_ch.ready is high only when the
// sequencer is idle. A sample runs the bit-serial modulo unit and then
// a walk that reads k (1..64) table entries, one RAM read per cycle.
// The result sits in an output register; a new word is accepted while it
// waits, and the sequencer holds its last step until the receiver takes
// it. Reset clears the sequencer, the running sum and the registers
// (multiplier 0, one entry in use); the table is not cleared.
`default_nettype none

module weighted_discrete_sampler (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [wds_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [wds_pkg::DATA_W-1:0]  pwdata,
    output logic [wds_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    wds_in_if.sink                           in_ch,
    wds_out_if.source                        out_ch
);
    import wds_pkg::*;

    state_t state_reg, state_next;

    logic [MULT_W-1:0]   mult_reg;
    logic [EIU_W-1:0]    eiu_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [WEIGHT_W-1:0] base_reg;
    logic [15:0]         extra_reg;
    logic [RAND_W-1:0]   rnd_reg;
    logic signed [32:0]  prod_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [SUM_W-1:0]    running_reg;
    logic [SUM_W-1:0]    target_reg;
    logic [IDX_W-1:0]    cur_reg;
    logic                out_valid_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic                out_status_reg;

    logic                cfg_wr;
    logic                accept;
    logic                out_free;
    logic [IDX_W-1:0]    last_idx;
    logic signed [32:0]  prod_next;
    logic signed [32:0]  prod_adj;
    logic signed [24:0]  quot;
    logic signed [25:0]  wsum;
    logic [WEIGHT_W-1:0] weight_next;
    logic [SUM_W:0]      sum_ext;
    logic [SUM_W-1:0]    sum_sat;
    logic                walk_stop;

    // Sequencer outputs.
    logic                ram_we;
    logic [IDX_W-1:0]    ram_raddr;
    logic [SUM_W-1:0]    ram_rdata;
    logic                emit;
    logic [IDX_W-1:0]    emit_idx;
    logic                emit_status;
    mod_req_t            mod_req;
    mod_rsp_t            mod_rsp;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            unique case (paddr[2])
                REG_MULT: prdata = {{(DATA_W-MULT_W){1'b0}}, mult_reg};
                REG_EIU:  prdata = {{(DATA_W-EIU_W){1'b0}}, eiu_reg};
                default:  prdata = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= '0;
            eiu_reg  <= EIU_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_MULT: mult_reg <= pwdata[MULT_W-1:0];
                REG_EIU:  eiu_reg  <= pwdata[EIU_W-1:0];
                default:  mult_reg <= mult_reg;
            endcase
        end
    end

    // Index of the last entry in use; zero counts as one entry.
    always_comb
    begin
        if (eiu_reg == '0)
        begin
            last_idx = '0;
        end
        else if (eiu_reg > EIU_W'(MAX_ENTRIES))
        begin
            last_idx = IDX_W'(MAX_ENTRIES - 1);
        end
        else
        begin
            last_idx = IDX_W'(eiu_reg - EIU_W'(1));
        end
    end

    // ---------------- weight arithmetic ----------------
    assign prod_next = $signed({{17{extra_reg[15]}}, extra_reg})
                     * $signed({17'd0, mult_reg});

    // Division by 256 rounding toward zero: bias negative products first.
    assign prod_adj = prod_reg + (prod_reg[32] ? 33'sd255 : 33'sd0);
    assign quot     = prod_adj[32:8];
    assign wsum     = $signed({quot[24], quot}) + $signed({10'd0, base_reg});

    always_comb
    begin
        if (wsum[25])
        begin
            weight_next = '0;
        end
        else if (wsum[24:16] != '0)
        begin
            weight_next = '1;
        end
        else
        begin
            weight_next = wsum[15:0];
        end
    end

    // Entry zero restarts the running sum; the sum saturates.
    assign sum_ext = {1'b0, (idx_reg == '0) ? {SUM_W{1'b0}} : running_reg}
                   + {{(SUM_W+1-WEIGHT_W){1'b0}}, weight_reg};
    assign sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

    assign walk_stop = (ram_rdata >= target_reg) || (cur_reg == last_idx);

    // ---------------- sequencer ----------------
    assign out_free = !out_valid_reg || out_ch.ready;
    assign accept   = in_ch.valid && in_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = (in_ch.op == OP_SAMPLE) ? ST_SM_TOT_RD : ST_LD_MUL;
                end
            end
            ST_LD_MUL:    state_next = ST_LD_WGT;
            ST_LD_WGT:    state_next = ST_LD_SUM;
            ST_LD_SUM:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SM_TOT_RD: state_next = ST_SM_TOT_CHK;
            ST_SM_TOT_CHK:
            begin
                if (ram_rdata != '0)
                begin
                    state_next = ST_SM_MOD;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SM_MOD:
            begin
                if (mod_rsp.done)
                begin
                    state_next = ST_SM_WALK;
                end
            end
            ST_SM_WALK:
            begin
                if (walk_stop && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready      = 1'b0;
        ram_we           = 1'b0;
        ram_raddr        = last_idx;
        emit             = 1'b0;
        emit_idx         = '0;
        emit_status      = STAT_OK;
        mod_req.start    = 1'b0;
        mod_req.dividend = rnd_reg;
        mod_req.divisor  = ram_rdata;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            ST_LD_SUM:
            begin
                ram_we = out_free;
                emit   = out_free;
            end
            ST_SM_TOT_CHK:
            begin
                if (ram_rdata != '0)
                begin
                    mod_req.start = 1'b1;
                end
                else
                begin
                    emit        = out_free;
                    emit_status = STAT_ZERO_TOTAL;
                end
            end
            ST_SM_MOD:
            begin
                // Entry zero is read here so the walk starts with its data.
                ram_raddr = '0;
            end
            ST_SM_WALK:
            begin
                ram_raddr = walk_stop ? cur_reg : cur_reg + 1'b1;
                emit      = walk_stop && out_free;
                emit_idx  = cur_reg;
            end
            default:
            begin
                ram_raddr = last_idx;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                running_reg <= sum_sat;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg   <= in_ch.entry_index;
            base_reg  <= in_ch.base_weight;
            extra_reg <= in_ch.extra_weight;
            rnd_reg   <= in_ch.random_value;
        end
        if (state_reg == ST_LD_MUL)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_LD_WGT)
        begin
            weight_reg <= weight_next;
        end
        if (mod_rsp.done)
        begin
            target_reg <= mod_rsp.remainder + 1'b1;
            cur_reg    <= '0;
        end
        else if (state_reg == ST_SM_WALK && !walk_stop)
        begin
            cur_reg <= cur_reg + 1'b1;
        end
        if (emit)
        begin
            out_idx_reg    <= emit_idx;
            out_status_reg <= emit_status;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.chosen_index = out_idx_reg;
    assign out_ch.status       = out_status_reg;

    // ---------------- cumulative table and modulo unit ----------------
    wds_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (sum_sat),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wds_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

endmodule

`default_nettype wire

// File: hw/rtl/wds_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module wds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/wds_mod.sv
// Bit-serial restoring modulo unit: one dividend bit per cycle.
// Depends on wds_pkg for widths and the request and response structs.
`default_nettype none

module wds_mod (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wds_pkg::mod_req_t req,
    output wds_pkg::mod_rsp_t      rsp
);
    import wds_pkg::*;

    logic               active_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [RAND_W-1:0]  dvd_reg;
    logic [SUM_W-1:0]   dvs_reg;
    logic [SUM_W-1:0]   rem_reg;
    logic [SUM_W:0]     trial;
    logic [SUM_W-1:0]   rem_next;

    // The partial remainder stays below the divisor, so the trial value
    // needs only one bit more than the divisor.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[RAND_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = SUM_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= CNT_W'(RAND_W);
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (active_reg)
        begin
            dvd_reg <= {dvd_reg[RAND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire
